@@ sv/sorted_list_queue_defines.svh @@
// assertion macros shared by the sorted list queue rtl
`ifndef SORTED_LIST_QUEUE_DEFINES_SVH
`define SORTED_LIST_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SLQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SLQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/slq_pkg.sv @@
// types and codes of the sorted list queue
package slq_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_INS   = 2'd1,
        CELL_DEL   = 2'd2,
        CELL_CLR   = 2'd3
    } t_cell_op;

    typedef logic signed [VALUE_W-1:0] t_value;

    // command broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op op;
        t_value   value;
    } t_cell_cmd;

endpackage

@@ sv/slq_if.sv @@
// valid/ready channel interfaces of the sorted list queue
interface slq_in_if import slq_pkg::*; ();
    logic   valid;
    logic   ready;
    t_mode  mode;
    t_value value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface slq_out_if import slq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_status               status;
    t_value                smallest;
    logic [COUNT_W-1:0]    count;

    modport source (output valid, output status, output smallest, output count, input ready);
    modport sink   (input valid, input status, input smallest, input count, output ready);
endinterface

@@ sv/slq_cell.sv @@
// one storage cell of the sorted chain
module slq_cell import slq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_value    i_left_entry,
    input  logic      i_left_valid,
    input  logic      i_left_ge,
    input  t_value    i_right_entry,
    input  logic      i_right_valid,
    output t_value    o_entry,
    output logic      o_valid,
    output logic      o_ge,
    output logic      o_first_eq
);

    logic   r_valid;
    logic   n_valid;
    t_value r_entry;
    t_value n_entry;

    // empty cells count as greater or equal so the boundary stays monotone
    assign o_ge       = !r_valid || (r_entry >= i_cmd.value);
    assign o_first_eq = r_valid && (r_entry == i_cmd.value) && !i_left_ge;
    assign o_entry    = r_entry;
    assign o_valid    = r_valid;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        case (i_cmd.op)
            CELL_INS: begin
                if (o_ge) begin
                    if (i_left_ge) begin
                        n_valid = i_left_valid;
                        n_entry = i_left_entry;
                    end else begin
                        n_valid = 1'b1;
                        n_entry = i_cmd.value;
                    end
                end
            end
            CELL_DEL: begin
                if (o_ge) begin
                    n_valid = i_right_valid;
                    n_entry = i_right_entry;
                end
            end
            CELL_CLR: begin
                n_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ sv/sorted_list_queue.sv @@
// sorted list priority queue: one transfer per cycle over a chain of cells
// latency: a result is shown the cycle after its input transfer
// throughput: one operation per cycle while results are taken, set by the update of the cell chain
// a new input transfer is taken while the previous result is taken in the same cycle
// reset (synchronous, active low) empties the store and drops any pending result
`include "sorted_list_queue_defines.svh"

module sorted_list_queue import slq_pkg::*; #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slq_in_if.sink     i_in,
    slq_out_if.source  o_out
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    // chain wiring, one entry per cell
    t_value            w_entry    [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_ge;
    logic [CAPACITY-1:0] w_first_eq;

    t_cell_cmd         w_cmd;
    logic              w_accept;
    logic              w_full;
    logic              w_found;

    logic              r_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W+COUNT_W-1:0] w_count_ext;

    // a pending result is held until taken; a new transfer may enter as it leaves
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    // entries are sorted, so only the first cell at or above the value can match
    assign w_found = |w_first_eq;

    // command broadcast to every cell
    always_comb begin
        w_cmd.value = i_in.value;
        w_cmd.op    = CELL_HOLD;
        if (w_accept) begin
            case (i_in.mode)
                MODE_INSERT: w_cmd.op = w_full  ? CELL_HOLD : CELL_INS;
                MODE_DELETE: w_cmd.op = w_found ? CELL_DEL  : CELL_HOLD;
                MODE_CLEAR:  w_cmd.op = CELL_CLR;
                default:     w_cmd.op = CELL_HOLD;
            endcase
        end
    end

    // status and count that go with the transfer
    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        case (i_in.mode)
            MODE_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            MODE_DELETE: begin
                if (w_found) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            MODE_PEEK: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // the cell chain; each cell sees its left and right neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_value w_left_entry;
        logic   w_left_valid;
        logic   w_left_ge;
        t_value w_right_entry;
        logic   w_right_valid;

        if (g == 0) begin : g_head
            assign w_left_entry = '0;
            assign w_left_valid = 1'b0;
            assign w_left_ge    = 1'b0;
        end else begin : g_body
            assign w_left_entry = w_entry[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_left_ge    = w_ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_entry = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_entry = w_entry[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        slq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_left_entry  (w_left_entry),
            .i_left_valid  (w_left_valid),
            .i_left_ge     (w_left_ge),
            .i_right_entry (w_right_entry),
            .i_right_valid (w_right_valid),
            .o_entry       (w_entry[g]),
            .o_valid       (w_valid[g]),
            .o_ge          (w_ge[g]),
            .o_first_eq    (w_first_eq[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
        end
    end

    // smallest read straight from the chain, count from its register: both only move on a transfer,
    // and a transfer is only taken when no result is pending or the pending result leaves
    assign w_count_ext    = {{COUNT_W{1'b0}}, r_count};
    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_status;
    assign o_out.smallest = w_valid[0] ? w_entry[0] : '0;
    assign o_out.count    = w_count_ext[COUNT_W-1:0];

    // occupied cells and the entry count agree
    `SLQ_ASSERT_NOW(a_count_matches_cells, 1'b1,
        $countones(w_valid) == r_count, "cell occupancy differs from entry count")
    // the head cell is occupied whenever the store is not empty
    `SLQ_ASSERT_NOW(a_head_valid, r_count != '0, w_valid[0], "head cell empty while count nonzero")
    // clear empties the store
    `SLQ_ASSERT_NEXT(a_clear_empties, w_accept && (i_in.mode == MODE_CLEAR),
        r_count == '0, "store not empty after clear")
    // insert into a full store leaves the count alone
    `SLQ_ASSERT_NEXT(a_full_holds, w_accept && (i_in.mode == MODE_INSERT) && w_full,
        $stable(r_count), "count changed on insert into full store")

endmodule
